[rtl/i2cm_pkg.sv]
// Shared types and codes for the I2C master transfer sequencer.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

  typedef enum logic [1:0] {
    ACT_START_WRITE = 2'd0,
    ACT_START_READ  = 2'd1,
    ACT_EVENT       = 2'd2,
    ACT_ERROR       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACK_NONE    = 2'd0,
    ACK_ENABLE  = 2'd1,
    ACK_DISABLE = 2'd2
  } ack_cmd_t;

  typedef enum logic [1:0] {
    COMPL_NONE  = 2'd0,
    COMPL_WRITE = 2'd1,
    COMPL_READ  = 2'd2,
    COMPL_ERROR = 2'd3
  } compl_t;

  // One request as held in the input register.
  typedef struct packed {
    action_t     action;
    logic [6:0]  addr7;
    logic [15:0] length;
    logic        start_sent;
    logic        address_sent;
    logic        tx_empty;
    logic        transfer_complete;
    logic        rx_not_empty;
    logic [7:0]  tx_data;
    logic [7:0]  rx_data;
    logic [3:0]  error_bits;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    status_t     start_status;
    logic        issue_start;
    logic        send_address;
    logic [7:0]  address_byte;
    logic        byte_strobe;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    ack_cmd_t    ack_command;
    logic        issue_stop;
    compl_t      completion;
    logic [3:0]  error_report;
    logic        busy_res;
  } res_t;

endpackage

[rtl/i2cm_step.sv]
// Transfer state and per-request command decode.
// Depends on i2cm_pkg. State advances only when the request moves on.
module i2cm_step import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  req_t req,
  output res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WADDR = 3'd1,
    PH_WDATA = 3'd2,
    PH_RADDR = 3'd3,
    PH_RDATA = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  target_byte, target_byte_next;
  logic [15:0] total_bytes, total_bytes_next;
  logic [15:0] done_bytes, done_bytes_next;
  logic [15:0] done_inc;
  logic [15:0] total_m1;
  logic [15:0] total_m2;

  assign done_inc = done_bytes + 16'd1;
  assign total_m1 = total_bytes - 16'd1;
  assign total_m2 = total_bytes - 16'd2;

  always_comb begin
    phase_next       = phase;
    target_byte_next = target_byte;
    total_bytes_next = total_bytes;
    done_bytes_next  = done_bytes;
    res              = '0;

    unique case (req.action)
      ACT_START_WRITE, ACT_START_READ: begin
        if (phase != PH_IDLE) begin
          res.start_status = STATUS_BUSY;
        end else if (req.length == 16'd0) begin
          res.start_status = STATUS_INVALID;
        end else begin
          target_byte_next = {req.addr7, req.action == ACT_START_READ};
          total_bytes_next = req.length;
          done_bytes_next  = 16'd0;
          if (req.action == ACT_START_READ) begin
            phase_next      = PH_RADDR;
            res.ack_command = ACK_ENABLE;
          end else begin
            phase_next = PH_WADDR;
          end
          res.issue_start = 1'b1;
        end
      end
      ACT_ERROR: begin
        res.issue_stop   = 1'b1;
        res.completion   = COMPL_ERROR;
        res.error_report = req.error_bits;
        phase_next       = PH_IDLE;
      end
      default: begin
        unique case (phase)
          PH_WADDR, PH_RADDR: begin
            if (req.start_sent) begin
              res.send_address = 1'b1;
              res.address_byte = target_byte;
              phase_next = (phase == PH_RADDR) ? PH_RDATA : PH_WDATA;
            end
          end
          PH_WDATA: begin
            if (req.tx_empty) begin
              if (done_bytes < total_bytes) begin
                res.byte_strobe = 1'b1;
                res.data_byte   = req.tx_data;
                res.byte_index  = done_bytes;
                done_bytes_next = done_inc;
              end else if (req.transfer_complete) begin
                res.issue_stop = 1'b1;
                res.completion = COMPL_WRITE;
                phase_next     = PH_IDLE;
              end
            end
          end
          PH_RDATA: begin
            if (req.address_sent && total_bytes == 16'd1) begin
              res.ack_command = ACK_DISABLE;
              res.issue_stop  = 1'b1;
            end
            if (req.rx_not_empty) begin
              // NACK goes out with the byte before the last, STOP with the last byte
              if (total_bytes >= 16'd2 && done_bytes == total_m2) begin
                res.ack_command = ACK_DISABLE;
              end else if (done_bytes == total_m1) begin
                res.issue_stop = 1'b1;
              end
              res.byte_strobe = 1'b1;
              res.data_byte   = req.rx_data;
              res.byte_index  = done_bytes;
              done_bytes_next = done_inc;
              if (done_inc == total_bytes) begin
                res.issue_stop = 1'b1;
                res.completion = COMPL_READ;
                phase_next     = PH_IDLE;
              end
            end
          end
          default: begin
            // event with no transfer running: force the bus free
            res.issue_stop = 1'b1;
            phase_next     = PH_IDLE;
          end
        endcase
      end
    endcase

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      target_byte <= 8'd0;
      total_bytes <= 16'd0;
      done_bytes  <= 16'd0;
    end else if (adv) begin
      phase       <= phase_next;
      target_byte <= target_byte_next;
      total_bytes <= total_bytes_next;
      done_bytes  <= done_bytes_next;
    end
  end

endmodule

[rtl/i2cm_out_reg.sv]
// Result register of the sequencer with its valid/ready handshake.
// Depends on i2cm_pkg for the result type.
module i2cm_out_reg import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output res_t res_out
);

  // the register can take a new result when empty or emptying this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/i2c_master_transfer_sequencer.sv]
// Top level of the I2C master transfer sequencer.
// Depends on i2cm_pkg, i2cm_step and i2cm_out_reg.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready) is a start-write,
//   start-read, peripheral event or error event with its flags and data.
//   Every request yields exactly one result on the output channel
//   (out_valid/out_ready) carrying the bus commands for that step: START,
//   address byte, data byte with its buffer index, ACK change, STOP,
//   completion code and the busy flag after the step.
//   A request held in the input register is decoded into the result register
//   as soon as the result register is free to take it.
//   Throughput: one request per cycle, sustained while out_ready stays high;
//   the decode is a handful of 16-bit compares, one increment and two
//   decrements between the two registers.
//   Reset (rst, synchronous) returns the sequencer to idle with the latched
//   address, byte count and byte counter cleared, and both registers empty.
//   When the receiver stalls, the result register holds; the input register
//   then holds its request, and in_ready falls once both are full.
//   Transfer state moves only when a request passes into the result
//   register, so stalls never drop or repeat a step.
module i2c_master_transfer_sequencer import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [6:0]  addr7,
  input  logic [15:0] length,
  input  logic        start_sent,
  input  logic        address_sent,
  input  logic        tx_empty,
  input  logic        transfer_complete,
  input  logic        rx_not_empty,
  input  logic [7:0]  tx_data,
  input  logic [7:0]  rx_data,
  input  logic [3:0]  error_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  start_status,
  output logic        issue_start,
  output logic        send_address,
  output logic [7:0]  address_byte,
  output logic        byte_strobe,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_index,
  output logic [1:0]  ack_command,
  output logic        issue_stop,
  output logic [1:0]  completion,
  output logic [3:0]  error_report,
  output logic        busy_res
);

  logic req_valid;
  req_t req;
  logic out_free;
  logic adv;
  res_t res_next;
  res_t res_q;

  assign adv      = req_valid && out_free;
  assign in_ready = !req_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.action            <= action_t'(action);
      req.addr7             <= addr7;
      req.length            <= length;
      req.start_sent        <= start_sent;
      req.address_sent      <= address_sent;
      req.tx_empty          <= tx_empty;
      req.transfer_complete <= transfer_complete;
      req.rx_not_empty      <= rx_not_empty;
      req.tx_data           <= tx_data;
      req.rx_data           <= rx_data;
      req.error_bits        <= error_bits;
    end
  end

  i2cm_step u_step (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (req),
    .res (res_next)
  );

  i2cm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res_in    (res_next),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign start_status = res_q.start_status;
  assign issue_start  = res_q.issue_start;
  assign send_address = res_q.send_address;
  assign address_byte = res_q.address_byte;
  assign byte_strobe  = res_q.byte_strobe;
  assign data_byte    = res_q.data_byte;
  assign byte_index   = res_q.byte_index;
  assign ack_command  = res_q.ack_command;
  assign issue_stop   = res_q.issue_stop;
  assign completion   = res_q.completion;
  assign error_report = res_q.error_report;
  assign busy_res     = res_q.busy_res;

endmodule

[rtl/i2cm_checker.sv]
// Port-level checks for the I2C master transfer sequencer.
// Depends on i2cm_pkg; bound to the top level below.
module i2cm_checker import i2cm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  start_status,
  input logic        issue_start,
  input logic        byte_strobe,
  input logic [7:0]  data_byte,
  input logic [15:0] byte_index,
  input logic        issue_stop,
  input logic [1:0]  completion,
  input logic        busy_res
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(completion) && $stable(byte_index))
    else $error("stalled result changed");

  // any completion ends the transfer with STOP
  a_compl_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && completion != COMPL_NONE |-> issue_stop && !busy_res)
    else $error("completion without STOP or still busy");

  // START only on an accepted start request, and the transfer is then running
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && issue_start |-> start_status == STATUS_OK && busy_res && !issue_stop)
    else $error("START with bad status or without busy");

  // rejected zero-length start leaves the sequencer idle
  a_invalid_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_status == STATUS_INVALID |-> !busy_res && !issue_start)
    else $error("invalid start changed state");

  // no data reported without a strobe
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_strobe |-> data_byte == 8'd0 && byte_index == 16'd0)
    else $error("data without strobe");

endmodule

bind i2c_master_transfer_sequencer i2cm_checker u_chk (.*);

[dv/i2c_master_transfer_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master transfer sequencer.
// Needs only i2cm_pkg and the i2c_master_transfer_sequencer RTL.
module i2c_master_transfer_sequencer_tb;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_REQUESTS = 2000;

  typedef enum logic [2:0] {
    XFER_IDLE    = 3'd0,
    XFER_WR_ADDR = 3'd1,
    XFER_WR_DATA = 3'd2,
    XFER_RD_ADDR = 3'd3,
    XFER_RD_DATA = 3'd4
  } xfer_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [6:0]  addr7 = '0;
  logic [15:0] length = '0;
  logic        start_sent = 1'b0;
  logic        address_sent = 1'b0;
  logic        tx_empty = 1'b0;
  logic        transfer_complete = 1'b0;
  logic        rx_not_empty = 1'b0;
  logic [7:0]  tx_data = '0;
  logic [7:0]  rx_data = '0;
  logic [3:0]  error_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  start_status;
  logic        issue_start;
  logic        send_address;
  logic [7:0]  address_byte;
  logic        byte_strobe;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [1:0]  ack_command;
  logic        issue_stop;
  logic [1:0]  completion;
  logic [3:0]  error_report;
  logic        busy_res;

  i2c_master_transfer_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .addr7(addr7), .length(length),
    .start_sent(start_sent), .address_sent(address_sent), .tx_empty(tx_empty),
    .transfer_complete(transfer_complete), .rx_not_empty(rx_not_empty),
    .tx_data(tx_data), .rx_data(rx_data), .error_bits(error_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_status(start_status), .issue_start(issue_start),
    .send_address(send_address), .address_byte(address_byte),
    .byte_strobe(byte_strobe), .data_byte(data_byte), .byte_index(byte_index),
    .ack_command(ack_command), .issue_stop(issue_stop), .completion(completion),
    .error_report(error_report), .busy_res(busy_res)
  );

  // Sequencer state as the testbench sees it
  xfer_phase_t seq_phase = XFER_IDLE;
  logic [7:0]  held_target = '0;
  logic [15:0] held_total = '0;
  logic [15:0] moved_bytes = '0;

  res_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned writes_done = 0;
  int unsigned reads_done = 0;
  int unsigned errors_done = 0;
  int unsigned busy_replies = 0;
  int unsigned bytes_strobed = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_transfer_sequencer regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none while steady is set.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_pause();
    end
  end

  // Advance the transfer by one request and return the bus commands it causes.
  function automatic res_t sequence_step(input req_t rq);
    res_t r;
    r = '0;
    if (rq.action == ACT_START_WRITE || rq.action == ACT_START_READ) begin
      if (seq_phase != XFER_IDLE) begin
        r.start_status = STATUS_BUSY;
      end else if (rq.length == 16'd0) begin
        r.start_status = STATUS_INVALID;
      end else begin
        held_target = {rq.addr7, rq.action == ACT_START_READ};
        held_total = rq.length;
        moved_bytes = '0;
        if (rq.action == ACT_START_READ) begin
          seq_phase = XFER_RD_ADDR;
          r.ack_command = ACK_ENABLE;
        end else begin
          seq_phase = XFER_WR_ADDR;
        end
        r.issue_start = 1'b1;
      end
    end else if (rq.action == ACT_ERROR) begin
      r.issue_stop = 1'b1;
      r.completion = COMPL_ERROR;
      r.error_report = rq.error_bits;
      seq_phase = XFER_IDLE;
    end else begin
      case (seq_phase)
        XFER_WR_ADDR, XFER_RD_ADDR: begin
          if (rq.start_sent) begin
            r.send_address = 1'b1;
            r.address_byte = held_target;
            seq_phase = (seq_phase == XFER_RD_ADDR) ? XFER_RD_DATA : XFER_WR_DATA;
          end
        end
        XFER_WR_DATA: begin
          if (rq.tx_empty) begin
            if (moved_bytes < held_total) begin
              r.byte_strobe = 1'b1;
              r.data_byte = rq.tx_data;
              r.byte_index = moved_bytes;
              moved_bytes = moved_bytes + 16'd1;
            end else if (rq.transfer_complete) begin
              r.issue_stop = 1'b1;
              r.completion = COMPL_WRITE;
              seq_phase = XFER_IDLE;
            end
          end
        end
        XFER_RD_DATA: begin
          // a single-byte read drops ACK and asks for STOP once addressed
          if (rq.address_sent && held_total == 16'd1) begin
            r.ack_command = ACK_DISABLE;
            r.issue_stop = 1'b1;
          end
          if (rq.rx_not_empty) begin
            if (held_total >= 16'd2 && moved_bytes == held_total - 16'd2)
              r.ack_command = ACK_DISABLE;
            else if (moved_bytes == held_total - 16'd1)
              r.issue_stop = 1'b1;
            r.byte_strobe = 1'b1;
            r.data_byte = rq.rx_data;
            r.byte_index = moved_bytes;
            moved_bytes = moved_bytes + 16'd1;
            if (moved_bytes == held_total) begin
              r.issue_stop = 1'b1;
              r.completion = COMPL_READ;
              seq_phase = XFER_IDLE;
            end
          end
        end
        default: begin
          r.issue_stop = 1'b1;
          seq_phase = XFER_IDLE;
        end
      endcase
    end
    r.busy_res = (seq_phase != XFER_IDLE);
    return r;
  endfunction

  function automatic req_t noise_request();
    req_t rq;
    rq.action = action_t'($urandom_range(3));
    rq.addr7 = 7'($urandom_range(127));
    rq.length = 16'($urandom_range(65535));
    rq.start_sent = coin();
    rq.address_sent = coin();
    rq.tx_empty = coin();
    rq.transfer_complete = coin();
    rq.rx_not_empty = coin();
    rq.tx_data = 8'($urandom_range(255));
    rq.rx_data = 8'($urandom_range(255));
    rq.error_bits = 4'($urandom_range(15));
    return rq;
  endfunction

  function automatic req_t start_request(input action_t kind, input logic [6:0] target,
                                         input logic [15:0] count);
    req_t rq;
    rq = noise_request();
    rq.action = kind;
    rq.addr7 = target;
    rq.length = count;
    return rq;
  endfunction

  function automatic req_t event_request(input logic sb, input logic as, input logic te,
                                         input logic tc, input logic rn);
    req_t rq;
    rq = noise_request();
    rq.action = ACT_EVENT;
    rq.start_sent = sb;
    rq.address_sent = as;
    rq.tx_empty = te;
    rq.transfer_complete = tc;
    rq.rx_not_empty = rn;
    return rq;
  endfunction

  function automatic req_t error_request(input logic [3:0] flags);
    req_t rq;
    rq = noise_request();
    rq.action = ACT_ERROR;
    rq.error_bits = flags;
    return rq;
  endfunction

  task automatic send_request(input req_t rq);
    int unsigned pause;
    res_t want;
    pause = pick_pause();
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= rq.action;
    addr7 <= rq.addr7;
    length <= rq.length;
    start_sent <= rq.start_sent;
    address_sent <= rq.address_sent;
    tx_empty <= rq.tx_empty;
    transfer_complete <= rq.transfer_complete;
    rx_not_empty <= rq.rx_not_empty;
    tx_data <= rq.tx_data;
    rx_data <= rq.rx_data;
    error_bits <= rq.error_bits;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    want = sequence_step(rq);
    pending_results.push_back(want);
    requests_sent++;
    if (want.completion == COMPL_WRITE) writes_done++;
    if (want.completion == COMPL_READ) reads_done++;
    if (want.completion == COMPL_ERROR) errors_done++;
    if (want.start_status == STATUS_BUSY) busy_replies++;
    if (want.byte_strobe) bytes_strobed++;
  endtask

  // Hold the sender off until every outstanding result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic flag_field(input string name, input logic [15:0] got,
                            input logic [15:0] want);
    if (got !== want) begin
      $display("[%0t] result %0d: %s is 0x%0h, want 0x%0h", $realtime, results_seen,
               name, got, want);
      mismatches++;
    end
  endtask

  // Sample at the falling edge: a result seen here is taken at the next rise.
  always @(negedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_field("unrequested result", 16'd1, 16'd0);
      end else begin
        want = pending_results.pop_front();
        flag_field("start_status", 16'(start_status), 16'(want.start_status));
        flag_field("issue_start", 16'(issue_start), 16'(want.issue_start));
        flag_field("send_address", 16'(send_address), 16'(want.send_address));
        flag_field("address_byte", 16'(address_byte), 16'(want.address_byte));
        flag_field("byte_strobe", 16'(byte_strobe), 16'(want.byte_strobe));
        flag_field("data_byte", 16'(data_byte), 16'(want.data_byte));
        flag_field("byte_index", byte_index, want.byte_index);
        flag_field("ack_command", 16'(ack_command), 16'(want.ack_command));
        flag_field("issue_stop", 16'(issue_stop), 16'(want.issue_stop));
        flag_field("completion", 16'(completion), 16'(want.completion));
        flag_field("error_report", 16'(error_report), 16'(want.error_report));
        flag_field("busy_res", 16'(busy_res), 16'(want.busy_res));
      end
      results_seen++;
    end
  end

  // One transfer with random content; long ones are cut short by an error.
  task automatic run_transfer();
    logic        rd;
    logic [15:0] count;
    int unsigned roll;
    int unsigned steps;
    req_t        rq;
    if (seq_phase != XFER_IDLE) send_request(error_request(4'($urandom_range(15))));
    rd = coin();
    roll = $urandom_range(99);
    if (roll < 70) count = 16'($urandom_range(4, 1));
    else if (roll < 95) count = 16'($urandom_range(24, 5));
    else count = 16'($urandom_range(65535, 25));
    steps = (count > 16'd24) ? $urandom_range(6, 1) : 32'(count);
    send_request(start_request(rd ? ACT_START_READ : ACT_START_WRITE,
                               7'($urandom_range(127)), count));
    if ($urandom_range(4) == 0)
      send_request(event_request(1'b0, coin(), coin(), coin(), coin()));
    send_request(event_request(1'b1, coin(), coin(), coin(), coin()));
    if (rd && count == 16'd1 && $urandom_range(3) != 0)
      send_request(event_request(coin(), 1'b1, coin(), coin(), 1'b0));
    for (int unsigned i = 0; i < steps; i++) begin
      if ($urandom_range(24) == 0) begin
        send_request(error_request(4'($urandom_range(15))));
        return;
      end
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1))
          send_request(start_request(action_t'($urandom_range(1)),
                                     7'($urandom_range(127)),
                                     16'($urandom_range(65535))));
        else
          send_request(event_request(coin(), coin(), 1'b0, coin(), 1'b0));
      end
      if (rd)
        rq = event_request(coin(), coin(), coin(), coin(), 1'b1);
      else
        rq = event_request(coin(), coin(), 1'b1, coin(), coin());
      send_request(rq);
    end
    if (count > 16'd24) begin
      send_request(error_request(4'($urandom_range(15))));
    end else if (!rd) begin
      if ($urandom_range(2) == 0)
        send_request(event_request(coin(), coin(), 1'b1, 1'b0, coin()));
      send_request(event_request(coin(), coin(), 1'b1, 1'b1, coin()));
    end
  endtask

  task automatic test_directed();
    req_t rq;
    send_request(event_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_request(error_request(4'hF));
    send_request(start_request(ACT_START_WRITE, 7'd9, 16'd0));
    send_request(start_request(ACT_START_READ, 7'd9, 16'd0));
    // single-byte write to the top address, with a busy start in between
    send_request(start_request(ACT_START_WRITE, 7'h7F, 16'd1));
    send_request(event_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    send_request(event_request(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(start_request(ACT_START_READ, 7'h00, 16'hFFFF));
    send_request(event_request(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    rq = event_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    rq.tx_data = 8'hFF;
    send_request(rq);
    send_request(event_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_request(event_request(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    // single-byte read: ACK off and STOP on the address event
    send_request(start_request(ACT_START_READ, 7'h00, 16'd1));
    send_request(event_request(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_request(event_request(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    rq = event_request(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    rq.rx_data = 8'hFF;
    send_request(rq);
    // two-byte read: ACK off with the first byte, STOP with the last
    send_request(start_request(ACT_START_READ, 7'h55, 16'd2));
    send_request(event_request(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    rq = event_request(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    rq.rx_data = 8'h00;
    send_request(rq);
    send_request(event_request(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    // longest write, aborted by an error with no flags
    send_request(start_request(ACT_START_WRITE, 7'h00, 16'hFFFF));
    send_request(event_request(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    rq = event_request(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    rq.tx_data = 8'h00;
    send_request(rq);
    send_request(error_request(4'h0));
  endtask

  task automatic test_drain_pause();
    for (int unsigned round = 0; round < 5; round++) begin
      run_transfer();
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = requests_sent + 300;
    steady = 1'b1;
    while (requests_sent < stop_at) run_transfer();
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned stop_at;
    int unsigned roll;
    stop_at = requests_sent + RANDOM_REQUESTS - 300;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 75) run_transfer();
      else if (roll < 88) send_request(noise_request());
      else if (roll < 94) send_request(error_request(4'($urandom_range(15))));
      else send_request(start_request(action_t'($urandom_range(1)),
                                      7'($urandom_range(127)),
                                      ($urandom_range(3) == 0) ? 16'd0
                                                               : 16'($urandom_range(65535))));
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_directed();
    test_drain_pause();
    test_back_to_back();
    test_random_mix();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, %0d mismatches.",
             requests_sent, results_seen, mismatches);
    $display("Writes done %0d, reads done %0d, errors %0d, busy replies %0d, bytes %0d.",
             writes_done, reads_done, errors_done, busy_replies, bytes_strobed);
    if (mismatches == 0)
      $display("i2c_master_transfer_sequencer regression: pass");
    else
      $display("i2c_master_transfer_sequencer regression: fail");
    $finish;
  end

endmodule
